// File: hdl/imufp_pkg.sv
// imufp_pkg: constants, types and helpers for the sensor frame parser
// no dependencies; used by imufp_kind_store and imu_frame_parser_unit

package imufp_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACCEL  = 8'h51;
  localparam logic [7:0] TYPE_MAG    = 8'h54;

  localparam int unsigned DATA_BYTES = 9;
  localparam logic [3:0]  SUM_POS    = 4'd10;
  localparam logic [3:0]  POS_IDLE   = 4'd0;
  localparam logic [3:0]  POS_FIRST  = 4'd1;

  localparam int unsigned KINDS      = 4;
  localparam int unsigned KIND_W     = $clog2(KINDS);
  localparam logic [2:0]  KIND_OTHER = 3'd4;

  typedef logic [KIND_W-1:0] kind_idx_t;
  typedef logic [31:0]       count_t;
  typedef logic [47:0]       value_row_t;

  typedef struct packed {
    logic      rd_en;
    kind_idx_t rd_kind;
    logic      cnt_we;
    kind_idx_t cnt_kind;
    logic      val_we;
    kind_idx_t val_kind;
  } store_ctl_t;

  function automatic logic is_known(input logic [7:0] t);
    return (t >= TYPE_ACCEL) && (t <= TYPE_MAG);
  endfunction

  function automatic kind_idx_t kind_of(input logic [7:0] t);
    logic [7:0] d;
    d = t - TYPE_ACCEL;
    return d[KIND_W-1:0];
  endfunction

endpackage

// File: hdl/imufp_kind_store.sv
// imufp_kind_store: per-kind frame counters and held sensor words
// synchronous memories, registered read; depends on imufp_pkg

module imufp_kind_store (
  input  logic                  clk,
  input  logic                  rst_n,
  input  imufp_pkg::store_ctl_t ctl,
  input  imufp_pkg::count_t     cnt_wdata,
  input  imufp_pkg::value_row_t val_wdata,
  output imufp_pkg::count_t     rd_count
);

  imufp_pkg::count_t     cnt_mem [imufp_pkg::KINDS];
  imufp_pkg::value_row_t val_mem [imufp_pkg::KINDS];

  logic [imufp_pkg::KINDS-1:0] cnt_vld_r;
  logic [imufp_pkg::KINDS-1:0] cnt_vld_nxt;
  imufp_pkg::count_t           rd_mem_r;
  logic                        rd_vld_r;

  // counter memory
  always_ff @(posedge clk) begin
    if (ctl.cnt_we) begin
      cnt_mem[ctl.cnt_kind] <= cnt_wdata;
    end
    if (ctl.rd_en) begin
      rd_mem_r <= cnt_mem[ctl.rd_kind];
    end
  end

  // held sensor words, one row of three words per kind
  always_ff @(posedge clk) begin
    if (ctl.val_we) begin
      val_mem[ctl.val_kind] <= val_wdata;
    end
  end

  always_comb begin
    cnt_vld_nxt = cnt_vld_r;
    if (ctl.cnt_we) begin
      cnt_vld_nxt[ctl.cnt_kind] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      cnt_vld_r <= cnt_vld_nxt;
      if (ctl.rd_en) begin
        rd_vld_r <= cnt_vld_r[ctl.rd_kind];
      end
    end
  end

  // an entry never written reads as zero
  assign rd_count = rd_vld_r ? rd_mem_r : '0;

endmodule

// File: hdl/imu_frame_parser_unit.sv
// imu_frame_parser_unit: top level of the 11-byte sensor frame parser
// depends on imufp_pkg and imufp_kind_store

// Takes one serial byte per cycle while not stalled. Frames start with 0x55,
// then a type byte, eight data bytes and a checksum equal to the 8-bit sum
// of the ten bytes before it; bad frames vanish with no result. A good frame
// gives one result: the checksum cycle issues the read of that kind's
// counter from its memory (known kinds only), then stage 1 increments it,
// writes it back and loads the output register. Input stalls only while
// stage 1 and the output register are both full and the output is stalled.
// Known kinds also store their first three words in a write-only row memory.

module imu_frame_parser_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_type_code,
  output logic [2:0]         out_sensor_kind,
  output logic signed [15:0] out_word_zero,
  output logic signed [15:0] out_word_one,
  output logic signed [15:0] out_word_two,
  output logic signed [15:0] out_word_three,
  output logic [31:0]        out_kind_count
);

  logic [3:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] fb_r [imufp_pkg::DATA_BYTES];
  logic [3:0] fb_idx;

  logic in_fire, chk_good, chk_known;
  logic [15:0] w0, w1, w2, w3;

  logic                   s1_v_r, s1_v_nxt, s1_fire;
  logic                   s1_known_r;
  imufp_pkg::kind_idx_t   s1_kind_r;
  logic [7:0]             s1_type_r;
  logic [15:0]            s1_w0_r, s1_w1_r, s1_w2_r, s1_w3_r;

  logic                   out_v_r, out_v_nxt;

  imufp_pkg::store_ctl_t  ctl;
  imufp_pkg::count_t      rd_count, cnt_inc;

  assign in_stall = s1_v_r && out_v_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign fb_idx   = pos_r - imufp_pkg::POS_FIRST;

  assign w0 = {fb_r[2], fb_r[1]};
  assign w1 = {fb_r[4], fb_r[3]};
  assign w2 = {fb_r[6], fb_r[5]};
  assign w3 = {fb_r[8], fb_r[7]};

  assign chk_good  = in_fire && (pos_r >= imufp_pkg::SUM_POS) && (in_rx_byte == sum_r);
  assign chk_known = imufp_pkg::is_known(fb_r[0]);

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (in_fire) begin
      if (pos_r == imufp_pkg::POS_IDLE) begin
        if (in_rx_byte == imufp_pkg::HEADER_BYTE) begin
          pos_nxt = imufp_pkg::POS_FIRST;
          sum_nxt = imufp_pkg::HEADER_BYTE;
        end
      end else if (pos_r < imufp_pkg::SUM_POS) begin
        pos_nxt = pos_r + 4'd1;
        sum_nxt = sum_r + in_rx_byte;
      end else begin
        pos_nxt = imufp_pkg::POS_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (pos_r != imufp_pkg::POS_IDLE) && (pos_r < imufp_pkg::SUM_POS)) begin
      fb_r[fb_idx] <= in_rx_byte;
    end
  end

  // stage 1: counter read in flight
  assign s1_fire  = s1_v_r && !(out_v_r && out_stall);
  assign s1_v_nxt = chk_good || (s1_v_r && !s1_fire);

  always_ff @(posedge clk) begin
    if (chk_good) begin
      s1_known_r <= chk_known;
      s1_kind_r  <= imufp_pkg::kind_of(fb_r[0]);
      s1_type_r  <= fb_r[0];
      s1_w0_r    <= w0;
      s1_w1_r    <= w1;
      s1_w2_r    <= w2;
      s1_w3_r    <= w3;
    end
  end

  always_comb begin
    ctl.rd_en    = chk_good && chk_known;
    ctl.rd_kind  = imufp_pkg::kind_of(fb_r[0]);
    ctl.cnt_we   = s1_fire && s1_known_r;
    ctl.cnt_kind = s1_kind_r;
    ctl.val_we   = chk_good && chk_known;
    ctl.val_kind = imufp_pkg::kind_of(fb_r[0]);
  end

  assign cnt_inc = rd_count + 32'd1;

  imufp_kind_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .cnt_wdata (cnt_inc),
    .val_wdata ({w2, w1, w0}),
    .rd_count  (rd_count)
  );

  // output register
  assign out_v_nxt = s1_fire || (out_v_r && out_stall);

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_type_code   <= s1_type_r;
      out_sensor_kind <= s1_known_r ? {1'b0, s1_kind_r} : imufp_pkg::KIND_OTHER;
      out_word_zero   <= s1_w0_r;
      out_word_one    <= s1_w1_r;
      out_word_two    <= s1_w2_r;
      out_word_three  <= s1_w3_r;
      out_kind_count  <= s1_known_r ? cnt_inc : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= imufp_pkg::POS_IDLE;
      sum_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign out_valid = out_v_r;

endmodule
